>>> rtl/indexed_sequence_store_core_assert.svh
// Assertion macros for the indexed sequence store.
// Included by iss_datapath, which checks its own logic; no dependencies.
`ifndef INDEXED_SEQUENCE_STORE_CORE_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_CORE_ASSERT_SVH

// Flag a condition that must never hold outside reset
`define ISS_ASSERT_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

// Check a consequence in the cycle after a trigger
`define ISS_ASSERT_NEXT(name, clk, rst, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/iss_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the indexed sequence store. No dependencies.
`default_nettype none

package iss_pkg;

  // Store geometry
  localparam int DEPTH     = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Field widths
  localparam int CMD_W     = 3;
  localparam int POS_W     = 8;
  localparam int VAL_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int OUT_POS_W = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_POP     = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_REPLACE = 3'd3,
    CMD_DUMP    = 3'd4
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;       // execute the accepted command
    logic dump_emit;  // emit the next stored value of a dump
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;  // output register can take a result this cycle
    logic empty;      // no stored values
    logic dump_final; // the dump index points at the last stored value
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/iss_ctrl.sv
// Controller state machine for the indexed sequence store.
// Depends on iss_pkg; drives command strobes into iss_datapath.
`default_nettype none

module iss_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_valid,
  output logic                         s_ready,
  input  wire logic [iss_pkg::CMD_W-1:0] in_command,
  input  wire iss_pkg::dp_stat_t       stat,
  output iss_pkg::ctrl_cmd_t           cmd
);
  import iss_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Take a transaction only when idle and the output register has room
  assign s_ready = (state == S_IDLE) && stat.slot_free;
  assign accept  = s_valid && s_ready;

  // Issue strobes and pick the next state
  always_comb begin
    cmd.exec      = accept;
    cmd.dump_emit = 1'b0;
    state_next    = state;
    case (state)
      S_IDLE: begin
        if (accept && (in_command == CMD_DUMP) && !stat.empty) begin
          state_next = S_DUMP;
        end
      end
      S_DUMP: begin
        cmd.dump_emit = stat.slot_free;
        if (stat.slot_free && stat.dump_final) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/iss_datapath.sv
// Datapath for the indexed sequence store: shifting register store, count,
// dump index and output register. Depends on iss_pkg and the assert macros.
`default_nettype none
`include "indexed_sequence_store_core_assert.svh"

module iss_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire iss_pkg::ctrl_cmd_t          cmd,
  output iss_pkg::dp_stat_t                stat,
  input  wire logic [iss_pkg::CMD_W-1:0]   in_command,
  input  wire logic [iss_pkg::POS_W-1:0]   in_position,
  input  wire logic [iss_pkg::VAL_W-1:0]   in_item_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [iss_pkg::STATUS_W-1:0]     out_status,
  output logic [iss_pkg::CNT_W-1:0]        out_count,
  output logic [iss_pkg::VAL_W-1:0]        out_value,
  output logic [iss_pkg::OUT_POS_W-1:0]    out_position,
  output logic                             out_last
);
  import iss_pkg::*;

  logic [VAL_W-1:0] entries [DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] dump_idx;

  logic             full;
  logic             pos_in_range;
  logic [IDX_W-1:0] pos_idx;
  logic             wr_tail;
  logic             wr_pos;
  logic             do_shift;
  logic             load_single;
  status_e_t        status_next;
  logic             pop_hit;
  logic             ins_full;

  assign full         = (count == CNT_W'(DEPTH));
  assign pos_in_range = (in_position < {{(POS_W-CNT_W){1'b0}}, count});
  assign pos_idx      = in_position[IDX_W-1:0];

  // Decode the accepted command into store updates and a status
  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    wr_tail     = 1'b0;
    wr_pos      = 1'b0;
    do_shift    = 1'b0;
    case (in_command)
      CMD_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          wr_tail    = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (pos_in_range) begin
          do_shift   = 1'b1;
          wr_pos     = 1'b1;
          count_next = count + CNT_W'(1);
        end else begin
          wr_tail    = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_REPLACE: begin
        if (pos_in_range) begin
          wr_pos = 1'b1;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          wr_tail    = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_DUMP: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Update the store: shift up past the insert point, then write
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (do_shift) begin
        for (int i = 1; i < DEPTH; i++) begin
          if (POS_W'(i) > in_position) begin
            entries[i] <= entries[i-1];
          end
        end
      end
      if (wr_pos) begin
        entries[pos_idx] <= in_item_value;
      end
      if (wr_tail) begin
        entries[count[IDX_W-1:0]] <= in_item_value;
      end
    end
  end

  // Hold the count and the dump index
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      dump_idx <= '0;
    end else if (cmd.exec) begin
      count    <= count_next;
      dump_idx <= '0;
    end else if (cmd.dump_emit) begin
      dump_idx <= dump_idx + IDX_W'(1);
    end
  end

  // A non-empty dump streams its results instead of one summary result
  assign load_single = cmd.exec && !((in_command == CMD_DUMP) && (count != '0));

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_single || cmd.dump_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_single) begin
      out_status   <= status_next;
      out_count    <= count_next;
      out_value    <= '0;
      out_position <= '0;
      out_last     <= 1'b1;
    end else if (cmd.dump_emit) begin
      out_status   <= ST_OK;
      out_count    <= count;
      out_value    <= entries[dump_idx];
      out_position <= OUT_POS_W'(dump_idx);
      out_last     <= stat.dump_final;
    end
  end

  assign stat.slot_free  = !out_valid || out_ready;
  assign stat.empty      = (count == '0);
  assign stat.dump_final = ({1'b0, dump_idx} == (count - CNT_W'(1)));

  // Trigger terms for the checks below
  assign pop_hit  = cmd.exec && (in_command == CMD_POP) && (count != '0);
  assign ins_full = cmd.exec && (in_command == CMD_INSERT) && full;

  `ISS_ASSERT_NEVER(a_exec_emit_excl, clk, rst, cmd.exec && cmd.dump_emit, "exec during dump")
  `ISS_ASSERT_NEVER(a_emit_nonempty, clk, rst, cmd.dump_emit && stat.empty, "dump while empty")
  `ISS_ASSERT_NEXT(a_pop_dec, clk, rst, pop_hit, count == $past(count) - CNT_W'(1), "bad pop")
  `ISS_ASSERT_NEXT(a_insert_full, clk, rst, ins_full, count == $past(count), "insert grew")

endmodule

`default_nettype wire

>>> rtl/indexed_sequence_store_core.sv
// Indexed sequence store: an ordered list of up to 32 signed 32-bit values.
// Commands arrive on the s_axis channel: s_axis_tuser carries the command
// (append, pop, insert, replace, dump), s_axis_tdata the position and value.
// Results leave on the m_axis channel; m_axis_tlast marks the final result
// of each command.
// Every command except a non-empty dump gives one result, registered and
// visible the cycle after the transaction; while m_axis_tready is high the
// block takes a new command each cycle: throughput is one command per cycle.
// A dump of n stored values first moves the controller into its dump state,
// which loads the results into the output register, one per cycle while
// m_axis_tready is high; the next command is taken once the last result is
// in the output register.
// Inserts shift every entry above the position as they write the new value.
// When the receiver holds m_axis_tready low, the pending result holds and
// s_axis_tready drops until the output register frees up.
// Reset empties the store (count zero) and clears the output valid flag;
// stored values are undefined until written.
// Depends on iss_pkg, iss_ctrl and iss_datapath.
`default_nettype none

module indexed_sequence_store_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] position, [39:8] item_value
  input  wire logic [iss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [2:0] command
  input  wire logic [iss_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [1:0] status, [7:2] count, [39:8] out_value, [44:40] out_position,
  // [47:45] zero
  output logic [iss_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import iss_pkg::*;

  ctrl_cmd_t             cmd;
  dp_stat_t              stat;
  logic [STATUS_W-1:0]   out_status;
  logic [CNT_W-1:0]      out_count;
  logic [VAL_W-1:0]      out_value;
  logic [OUT_POS_W-1:0]  out_position;

  iss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .in_command (s_axis_tuser),
    .stat       (stat),
    .cmd        (cmd)
  );

  iss_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_command    (s_axis_tuser),
    .in_position   (s_axis_tdata[POS_W-1:0]),
    .in_item_value (s_axis_tdata[POS_W +: VAL_W]),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_value     (out_value),
    .out_position  (out_position),
    .out_last      (m_axis_tlast)
  );

  // Pack the result fields, lowest first, zero pad to whole bytes
  assign m_axis_tdata = {
    {(OUT_DATA_W - OUT_POS_W - VAL_W - CNT_W - STATUS_W){1'b0}},
    out_position, out_value, out_count, out_status
  };

endmodule

`default_nettype wire
